// ----- hdl/ab2lp_pkg.sv -----
// Shared types and constants for the Annex B to length-prefixed NAL converter.
package ab2lp_pkg;

  // Default width of the unit length counter.
  localparam int LENGTH_BITS_DEF = 32;

  // Width of the unit_length result field.
  localparam int LEN_W = 32;

  // Depth of the command queue between the front and back parts.
  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  // NAL unit types that mark a parameter set unit.
  localparam logic [6:0] TYPE_VPS = 7'h20;
  localparam logic [6:0] TYPE_SPS = 7'h21;
  localparam logic [6:0] TYPE_PPS = 7'h22;

  // Start code bytes and held zero count limit.
  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_ONE  = 8'h01;
  localparam logic [1:0] ZEROS_MAX = 2'd2;

  // Result kinds.
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_END     = 1'b1;

  // Destinations.
  localparam logic DEST_SAMPLE = 1'b0;
  localparam logic DEST_PARAM  = 1'b1;

  // Work for the back part caused by one input byte: first send zeros held
  // zeros, then the byte itself, then close the open unit.
  typedef struct packed {
    logic [1:0] zeros;
    logic       send;
    logic [7:0] data;
    logic       close;
  } cmd_t;

  // Destination of a unit given its first byte.
  function automatic logic dest_of(input logic [7:0] b);
    logic [6:0] t;
    t = b[7:1];
    if (t == TYPE_VPS || t == TYPE_SPS || t == TYPE_PPS) begin
      return DEST_PARAM;
    end
    return DEST_SAMPLE;
  endfunction

endpackage

// ----- hdl/ab2lp_front.sv -----
// Front part: start code detection and per-byte command generation.
module ab2lp_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [7:0]       byte_in,
  input  logic             final_byte,
  input  logic             q_full,
  output logic             cmd_valid,
  output ab2lp_pkg::cmd_t  cmd
);
  import ab2lp_pkg::*;

  logic [1:0] zero_state;
  logic       seen_start;
  logic       stream_done;

  logic [1:0] zero_state_next;
  logic       seen_start_next;
  logic       stream_done_next;
  logic       accept;
  cmd_t       cmd_next;

  assign accept = push && !q_full;

  // Classify the byte and decide what the back part has to send.
  always_comb begin
    zero_state_next  = zero_state;
    seen_start_next  = seen_start;
    stream_done_next = stream_done;
    cmd_next.zeros   = 2'd0;
    cmd_next.send    = 1'b0;
    cmd_next.data    = byte_in;
    cmd_next.close   = 1'b0;
    if (!stream_done) begin
      if (final_byte) begin
        if (seen_start) begin
          cmd_next.zeros = zero_state;
          cmd_next.send  = 1'b1;
          cmd_next.close = 1'b1;
        end
        zero_state_next  = 2'd0;
        stream_done_next = 1'b1;
      end else if (byte_in == BYTE_ZERO) begin
        if (zero_state < ZEROS_MAX) begin
          zero_state_next = zero_state + 2'd1;
        end else if (seen_start) begin
          // The oldest held zero belongs to the open unit.
          cmd_next.zeros = 2'd1;
        end
      end else if (byte_in == BYTE_ONE && zero_state == ZEROS_MAX) begin
        cmd_next.close  = seen_start;
        seen_start_next = 1'b1;
        zero_state_next = 2'd0;
      end else begin
        if (seen_start) begin
          cmd_next.zeros = zero_state;
          cmd_next.send  = 1'b1;
        end
        zero_state_next = 2'd0;
      end
    end
  end

  // Only requests that cause work enter the queue.
  assign cmd       = cmd_next;
  assign cmd_valid = accept &&
                     (cmd_next.zeros != 2'd0 || cmd_next.send || cmd_next.close);

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_state  <= 2'd0;
      seen_start  <= 1'b0;
      stream_done <= 1'b0;
    end else if (accept) begin
      zero_state  <= zero_state_next;
      seen_start  <= seen_start_next;
      stream_done <= stream_done_next;
    end
  end

endmodule

// ----- hdl/ab2lp_cmd_fifo.sv -----
// Short command queue that decouples the front part from the back part.
module ab2lp_cmd_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  ab2lp_pkg::cmd_t  wr_data,
  output logic             full,
  input  logic             rd_en,
  output ab2lp_pkg::cmd_t  rd_data,
  output logic             empty
);
  import ab2lp_pkg::*;

  cmd_t                 slots [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr;
  logic [CMD_PTR_W-1:0] rd_ptr;
  logic [CMD_CNT_W-1:0] count;
  logic                 do_wr;
  logic                 do_rd;

  assign full    = (count == CMD_CNT_W'(CMD_DEPTH));
  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

// ----- hdl/ab2lp_back.sv -----
// Back part: expands commands into payload and end-of-unit results.
module ab2lp_back #(
  parameter int LENGTH_BITS = ab2lp_pkg::LENGTH_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       head_valid,
  input  ab2lp_pkg::cmd_t            head,
  output logic                       deq,
  output logic                       empty,
  input  logic                       pop,
  output logic                       kind,
  output logic                       dest,
  output logic [7:0]                 data_byte,
  output logic                       unit_first,
  output logic [ab2lp_pkg::LEN_W-1:0] unit_length,
  output logic                       run_last
);
  import ab2lp_pkg::*;

  // Unit tracking.
  logic [LENGTH_BITS-1:0] unit_count;
  logic                   unit_dest;

  // Progress through the head command.
  logic [1:0] zeros_sent;
  logic       byte_sent;

  // Output register.
  logic out_valid;

  logic       out_free;
  logic       act_zero;
  logic       act_byte;
  logic       act_close;
  logic       cmd_last;
  logic       emit;
  logic [7:0] pay_byte;
  logic       pay_first;
  logic       pay_dest;

  assign out_free  = !out_valid || pop;
  assign act_zero  = head_valid && (zeros_sent < head.zeros);
  assign act_byte  = head_valid && !act_zero && head.send && !byte_sent;
  assign act_close = head_valid && !act_zero && !act_byte && head.close;
  assign pay_byte  = act_byte ? head.data : BYTE_ZERO;
  assign pay_first = (unit_count == '0);
  assign pay_dest  = pay_first ? dest_of(pay_byte) : unit_dest;

  // Decide whether the current step is the last one of the command.
  always_comb begin
    cmd_last = 1'b1;
    if (act_zero) begin
      cmd_last = (zeros_sent + 2'd1 == head.zeros) && !head.send && !head.close;
    end else if (act_byte) begin
      cmd_last = !head.close;
    end
  end

  assign emit  = act_zero || act_byte || (act_close && unit_count != '0);
  assign deq   = head_valid && out_free && cmd_last;
  assign empty = !out_valid;

  // Command stepping, unit state and control of the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      zeros_sent <= 2'd0;
      byte_sent  <= 1'b0;
      unit_count <= '0;
      unit_dest  <= DEST_SAMPLE;
      out_valid  <= 1'b0;
    end else if (out_free) begin
      out_valid <= emit;
      if (head_valid) begin
        if (cmd_last) begin
          zeros_sent <= 2'd0;
          byte_sent  <= 1'b0;
        end else if (act_zero) begin
          zeros_sent <= zeros_sent + 2'd1;
        end else begin
          byte_sent <= 1'b1;
        end
      end
      if (act_zero || act_byte) begin
        unit_dest <= pay_dest;
        if (unit_count != '1) begin
          unit_count <= unit_count + 1'b1;
        end
      end else if (act_close) begin
        unit_count <= '0;
        unit_dest  <= DEST_SAMPLE;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (out_free && emit) begin
      run_last <= cmd_last;
      if (act_close) begin
        kind        <= KIND_END;
        dest        <= unit_dest;
        data_byte   <= BYTE_ZERO;
        unit_first  <= 1'b0;
        unit_length <= LEN_W'(unit_count);
      end else begin
        kind        <= KIND_PAYLOAD;
        dest        <= pay_dest;
        data_byte   <= pay_byte;
        unit_first  <= pay_first;
        unit_length <= '0;
      end
    end
  end

endmodule

// ----- hdl/annexb_to_length_prefixed_nal_core.sv -----
// Annex B to length-prefixed NAL converter: top level.
// A byte's results pass through the command queue and output register.
// Throughput: one input byte per cycle while the queue has room; one result
// per cycle while popped, up to four for a byte that releases held zeros or
// closes a unit. A four-entry command queue lets input run ahead of results.
// Reset (rst, synchronous) clears the start code state, queue and results.
module annexb_to_length_prefixed_nal_core #(
  parameter int LENGTH_BITS = ab2lp_pkg::LENGTH_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [7:0]                  byte_in,
  input  logic                        final_byte,
  output logic                        empty,
  input  logic                        pop,
  output logic                        kind,
  output logic                        dest,
  output logic [7:0]                  data_byte,
  output logic                        unit_first,
  output logic [ab2lp_pkg::LEN_W-1:0] unit_length,
  output logic                        run_last
);
  import ab2lp_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  logic q_full;
  logic q_empty;
  cmd_t q_head;
  logic q_deq;

  assign full = q_full;

  // Start code detection.
  ab2lp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .byte_in    (byte_in),
    .final_byte (final_byte),
    .q_full     (q_full),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd)
  );

  // Command queue.
  ab2lp_cmd_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_valid),
    .wr_data (cmd),
    .full    (q_full),
    .rd_en   (q_deq),
    .rd_data (q_head),
    .empty   (q_empty)
  );

  // Result generation.
  ab2lp_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (!q_empty),
    .head        (q_head),
    .deq         (q_deq),
    .empty       (empty),
    .pop         (pop),
    .kind        (kind),
    .dest        (dest),
    .data_byte   (data_byte),
    .unit_first  (unit_first),
    .unit_length (unit_length),
    .run_last    (run_last)
  );

endmodule
